// ===== sv/boundary_tag_heap_allocator_unit_assert.svh =====
// Assertion shorthands for the heap allocator. Each expects clk and rst in scope.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define BTHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BTHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/btha_pkg.sv =====
package btha_pkg;

  // Offsets and tag words
  localparam int OFF_W  = 16;
  localparam int LINK_W = 12;
  localparam int CAP_BYTES = 4096;

  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [LINK_W-1:0] link_t;

  // Opcodes
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOT_INIT = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  // Config register indexes
  localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] CFG_HEAP_BYTES = 2'd1;

  localparam off_t TAG_ALLOC = 16'h8000;
  localparam off_t TAG_SIZE  = 16'h7fff;

  // Build a boundary tag from size and allocated flag
  function automatic off_t make_tag(input off_t sz, input logic alloc);
    make_tag = (sz & TAG_SIZE) | (alloc ? TAG_ALLOC : 16'h0000);
  endfunction

endpackage

// ===== sv/btha_if.sv =====
// Command channel
interface btha_req_if;
  import btha_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [12:0] request_bytes;
  logic [15:0] payload_addr;
  modport source (output valid, opcode, request_bytes, payload_addr, input ready);
  modport sink   (input valid, opcode, request_bytes, payload_addr, output ready);
endinterface

// Result channel
interface btha_rsp_if;
  import btha_pkg::*;
  logic        valid;
  logic        ready;
  logic [15:0] result_addr;
  logic [1:0]  status;
  modport source (output valid, result_addr, status, input ready);
  modport sink   (input valid, result_addr, status, output ready);
endinterface

// Register write channel
interface btha_cfg_if;
  import btha_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/boundary_tag_heap_allocator_unit.sv =====
// Channel  Role    Payload
// req      sink    opcode, request_bytes, payload_addr
// rsp      source  result_addr, status
// cfg      sink    reg_index, wdata (0 heap_base, 1 heap_bytes)
//
// One command at a time; the heap RAM sets the pace.
// Init writes the tags and links of one free chunk. Alloc checks each free chunk in
// list order, then reads its links and does 4..8 writes. Free walks the tags from offset 4,
// checks each neighbor and unlinks a merged one, then does 6 writes for the push.
// The result register holds until taken. rst is synchronous; heap RAM is not cleared.
module boundary_tag_heap_allocator_unit #(
  parameter int HEAP_WORDS = 2048
) (
  input logic       clk,
  input logic       rst,
  btha_req_if.sink  req,
  btha_rsp_if.source rsp,
  btha_cfg_if.sink  cfg
);
  import btha_pkg::*;

  `include "boundary_tag_heap_allocator_unit_assert.svh"

  localparam int CNT_W = $clog2(HEAP_WORDS + 1);
  localparam int CAP_RAW = 2 * HEAP_WORDS;
  localparam int CAP = (CAP_RAW > CAP_BYTES) ? CAP_BYTES : CAP_RAW;

  // Sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_A_TAG   = 5'd1;
  localparam logic [4:0] S_A_CHK   = 5'd2;
  localparam logic [4:0] S_A_WALK  = 5'd3;
  localparam logic [4:0] S_A_P     = 5'd4;
  localparam logic [4:0] S_A_N     = 5'd5;
  localparam logic [4:0] S_F_LOOP  = 5'd6;
  localparam logic [4:0] S_F_TAG   = 5'd7;
  localparam logic [4:0] S_F_LEFT  = 5'd8;
  localparam logic [4:0] S_F_LT    = 5'd9;
  localparam logic [4:0] S_F_RIGHT = 5'd10;
  localparam logic [4:0] S_F_RT    = 5'd11;
  localparam logic [4:0] S_U_RP    = 5'd12;
  localparam logic [4:0] S_U_RN    = 5'd13;
  localparam logic [4:0] S_U_W     = 5'd14;
  localparam logic [4:0] S_F_PUSH  = 5'd15;
  localparam logic [4:0] S_WRITE   = 5'd16;
  localparam logic [4:0] S_DONE    = 5'd17;

  // Write sequences
  localparam logic [2:0] K_INIT  = 3'd0;
  localparam logic [2:0] K_SPLIT = 3'd1;
  localparam logic [2:0] K_WHOLE = 3'd2;
  localparam logic [2:0] K_UNL   = 3'd3;
  localparam logic [2:0] K_FREE  = 3'd4;

  // Write step kinds
  localparam logic [1:0] W_MEM   = 2'd0;
  localparam logic [1:0] W_NEXT  = 2'd1;
  localparam logic [1:0] W_PREV  = 2'd2;
  localparam logic [1:0] W_FIRST = 2'd3;

  logic [4:0]  state, resume;
  logic [2:0]  kind, wstep;
  logic [CNT_W-1:0] walk;
  off_t        need, node, cs, rr, rs, off, sz, tgt, noff, nsz, cnode;
  link_t       p, nx, first, last;
  logic        heap_ready;
  off_t        cfg_base, base_l;
  logic [12:0] cfg_bytes, size_l;
  off_t        res_addr;
  logic [1:0]  res_status;
  logic        out_valid;
  off_t        out_addr;
  logic [1:0]  out_status;

  logic        rd_en, mem_we;
  off_t        rd_off, rd_data, mem_off, mem_wdata;
  logic [1:0]  wop;
  off_t        wx, wv;
  logic        wlast;

  btha_mem #(.HEAP_WORDS(HEAP_WORDS)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_off  (rd_off),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_off  (mem_off),
    .wr_data (mem_wdata)
  );

  assign req.ready       = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = out_valid;
  assign rsp.result_addr = out_addr;
  assign rsp.status      = out_status;

  // Derived values from the current read
  off_t       tag_sz;
  logic [16:0] off_end, off_plus8, right_off;
  off_t       size_w, left_off;
  assign tag_sz    = rd_data & TAG_SIZE;
  assign size_w    = {3'b0, size_l};
  assign off_end   = {1'b0, off} + {1'b0, tag_sz};
  assign off_plus8 = {1'b0, off} + 17'd8;
  assign right_off = {1'b0, off} + {1'b0, sz};
  assign left_off  = off - tag_sz;

  // Write micro-step table
  always_comb begin
    wop = W_MEM;
    wx  = '0;
    wv  = '0;
    wlast = 1'b0;
    case (kind)
      K_INIT: begin
        case (wstep)
          3'd0: begin wx = 16'd4; wv = make_tag(size_w - 16'd4, 1'b0); end
          3'd1: begin wx = size_w - 16'd2; wv = make_tag(size_w - 16'd4, 1'b0); end
          3'd2: begin wx = 16'd6; wv = '0; end
          default: begin wx = 16'd8; wv = '0; wlast = 1'b1; end
        endcase
      end
      K_SPLIT: begin
        case (wstep)
          3'd0: begin wx = rr; wv = make_tag(rs, 1'b0); end
          3'd1: begin wx = rr + rs - 16'd2; wv = make_tag(rs, 1'b0); end
          3'd2: begin wx = rr + 16'd2; wv = {4'b0, p}; end
          3'd3: begin wx = rr + 16'd4; wv = {4'b0, nx}; end
          3'd4: begin wop = W_NEXT; wx = {4'b0, p}; wv = rr; end
          3'd5: begin wop = W_PREV; wx = {4'b0, nx}; wv = rr; end
          3'd6: begin wx = node; wv = make_tag(need, 1'b1); end
          default: begin
            wx = node + need - 16'd2; wv = make_tag(need, 1'b1); wlast = 1'b1;
          end
        endcase
      end
      K_WHOLE: begin
        case (wstep)
          3'd0: begin wop = W_NEXT; wx = {4'b0, p}; wv = {4'b0, nx}; end
          3'd1: begin wop = W_PREV; wx = {4'b0, nx}; wv = {4'b0, p}; end
          3'd2: begin wx = node; wv = make_tag(cs, 1'b1); end
          default: begin
            wx = node + cs - 16'd2; wv = make_tag(cs, 1'b1); wlast = 1'b1;
          end
        endcase
      end
      K_UNL: begin
        case (wstep)
          3'd0: begin wop = W_NEXT; wx = {4'b0, p}; wv = {4'b0, nx}; end
          default: begin
            wop = W_PREV; wx = {4'b0, nx}; wv = {4'b0, p}; wlast = 1'b1;
          end
        endcase
      end
      default: begin
        case (wstep)
          3'd0: begin wx = noff; wv = make_tag(nsz, 1'b0); end
          3'd1: begin wx = noff + nsz - 16'd2; wv = make_tag(nsz, 1'b0); end
          3'd2: begin wx = noff + 16'd2; wv = '0; end
          3'd3: begin wx = noff + 16'd4; wv = {4'b0, first}; end
          3'd4: begin wop = W_PREV; wx = {4'b0, first}; wv = noff; end
          default: begin wop = W_FIRST; wv = noff; wlast = 1'b1; end
        endcase
      end
    endcase
  end

  // Resolve a step to a RAM write or a list register update
  always_comb begin
    mem_we    = 1'b0;
    mem_off   = wx;
    mem_wdata = wv;
    if (state == S_WRITE) begin
      case (wop)
        W_MEM:   mem_we = 1'b1;
        W_NEXT:  begin mem_we = (wx != '0); mem_off = wx + 16'd4; end
        W_PREV:  begin mem_we = (wx != '0); mem_off = wx + 16'd2; end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // Read port address per state
  always_comb begin
    rd_en  = 1'b1;
    rd_off = node;
    case (state)
      S_A_TAG:  rd_off = node;
      S_A_CHK:  rd_off = (tag_sz >= need) ? node + 16'd2 : node + 16'd4;
      S_A_P:    rd_off = node + 16'd4;
      S_F_LOOP: rd_off = off;
      S_F_LEFT: rd_off = off - 16'd2;
      S_F_RIGHT: rd_off = right_off[15:0];
      S_U_RP:   rd_off = cnode + 16'd2;
      S_U_RN:   rd_off = cnode + 16'd4;
      default:  rd_en = 1'b0;
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base  <= 16'd40960;
      cfg_bytes <= 13'd256;
    end else if (cfg.valid) begin
      if (cfg.reg_index == CFG_HEAP_BASE) begin
        cfg_base <= cfg.wdata;
      end else if (cfg.reg_index == CFG_HEAP_BYTES) begin
        cfg_bytes <= cfg.wdata[12:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_valid  <= 1'b1;
      out_addr   <= res_addr;
      out_status <= res_status;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Init size clamp
  logic [12:0] init_sz;
  always_comb begin
    init_sz = cfg_bytes & 13'h1ffe;
    if (init_sz > 13'(CAP)) init_sz = 13'(CAP);
    if (init_sz < 13'd16)   init_sz = 13'd16;
  end

  off_t need_raw, diff;
  assign need_raw = (({3'b0, req.request_bytes} + 16'd1) & 16'hfffe) + 16'd4;
  assign diff     = req.payload_addr - base_l;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      first      <= '0;
      last       <= '0;
      heap_ready <= 1'b0;
      base_l     <= '0;
      size_l     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_addr   <= '0;
            res_status <= ST_OK;
            if (req.opcode == OP_INIT) begin
              size_l     <= init_sz;
              base_l     <= cfg_base;
              first      <= link_t'(4);
              last       <= link_t'(4);
              heap_ready <= 1'b1;
              kind       <= K_INIT;
              wstep      <= '0;
              resume     <= S_DONE;
              state      <= S_WRITE;
            end else if (req.opcode == OP_NOP) begin
              state <= S_DONE;
            end else if (!heap_ready) begin
              res_status <= ST_NOT_INIT;
              state      <= S_DONE;
            end else if (req.opcode == OP_ALLOC) begin
              need  <= (need_raw < 16'd8) ? 16'd8 : need_raw;
              node  <= {4'b0, first};
              walk  <= '0;
              state <= S_A_TAG;
            end else if (diff < 16'd2) begin
              res_status <= ST_BAD_FREE;
              state      <= S_DONE;
            end else begin
              tgt   <= diff - 16'd2;
              off   <= 16'd4;
              state <= S_F_LOOP;
            end
          end
        end
        S_A_TAG: begin
          if (node == '0 || walk >= CNT_W'(HEAP_WORDS)) begin
            res_status <= ST_NOFIT;
            state      <= S_DONE;
          end else begin
            state <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          cs    <= tag_sz;
          state <= (tag_sz >= need) ? S_A_P : S_A_WALK;
        end
        S_A_WALK: begin
          node  <= {4'b0, rd_data[LINK_W-1:0]};
          walk  <= walk + 1'b1;
          state <= S_A_TAG;
        end
        S_A_P: begin
          p     <= rd_data[LINK_W-1:0];
          state <= S_A_N;
        end
        S_A_N: begin
          nx       <= rd_data[LINK_W-1:0];
          rr       <= node + need;
          rs       <= cs - need;
          kind     <= (cs - need >= 16'd8) ? K_SPLIT : K_WHOLE;
          wstep    <= '0;
          res_addr <= base_l + node + 16'd2;
          resume   <= S_DONE;
          state    <= S_WRITE;
        end
        S_F_LOOP: begin
          if (off_plus8 > {4'b0, size_l}) begin
            res_status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else begin
            state <= S_F_TAG;
          end
        end
        S_F_TAG: begin
          sz <= tag_sz;
          if (tag_sz < 16'd8 || off_end > {4'b0, size_l} || off > tgt) begin
            res_status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else if (off == tgt) begin
            if (rd_data[15]) begin
              state <= S_F_LEFT;
            end else begin
              res_status <= ST_BAD_FREE;
              state      <= S_DONE;
            end
          end else begin
            off   <= off_end[15:0];
            state <= S_F_LOOP;
          end
        end
        S_F_LEFT: begin
          noff  <= off;
          nsz   <= sz;
          state <= (off > 16'd4) ? S_F_LT : S_F_RIGHT;
        end
        S_F_LT: begin
          if (!rd_data[15]) begin
            noff   <= left_off;
            nsz    <= sz + tag_sz;
            cnode  <= left_off;
            resume <= S_F_RIGHT;
            state  <= S_U_RP;
          end else begin
            state <= S_F_RIGHT;
          end
        end
        S_F_RIGHT: begin
          state <= (right_off < {4'b0, size_l}) ? S_F_RT : S_F_PUSH;
        end
        S_F_RT: begin
          if (!rd_data[15]) begin
            nsz    <= nsz + tag_sz;
            cnode  <= right_off[15:0];
            resume <= S_F_PUSH;
            state  <= S_U_RP;
          end else begin
            state <= S_F_PUSH;
          end
        end
        S_U_RP: state <= S_U_RN;
        S_U_RN: begin
          p     <= rd_data[LINK_W-1:0];
          state <= S_U_W;
        end
        S_U_W: begin
          nx    <= rd_data[LINK_W-1:0];
          kind  <= K_UNL;
          wstep <= '0;
          state <= S_WRITE;
        end
        S_F_PUSH: begin
          kind   <= K_FREE;
          wstep  <= '0;
          resume <= S_DONE;
          state  <= S_WRITE;
        end
        S_WRITE: begin
          if (wop == W_FIRST || (wop == W_NEXT && wx == '0)) begin
            first <= wv[LINK_W-1:0];
          end
          if (wop == W_PREV && wx == '0) begin
            last <= wv[LINK_W-1:0];
          end
          wstep <= wstep + 1'b1;
          if (wlast) begin
            state <= resume;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BTHA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, state != S_IDLE, "idle after accept")
  `BTHA_ASSERT_NOW(a_ram_write_in_seq, mem_we, state == S_WRITE, "RAM write outside sequence")
  `BTHA_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state) == S_DONE, "stray result")
  `BTHA_ASSERT_NOW(a_list_empty_uninit, !heap_ready, first == '0 && last == '0, "list before init")

endmodule

// ===== sv/btha_mem.sv =====
module btha_mem #(
  parameter int HEAP_WORDS = 2048
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [btha_pkg::OFF_W-1:0] rd_off,
  output logic [btha_pkg::OFF_W-1:0] rd_data,
  input  logic                   wr_en,
  input  logic [btha_pkg::OFF_W-1:0] wr_off,
  input  logic [btha_pkg::OFF_W-1:0] wr_data
);
  import btha_pkg::*;

  localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;

  logic [OFF_W-1:0] words [HEAP_WORDS];
  logic             rd_in, wr_in;

  // Byte offsets beyond the array read as zero and drop writes
  assign rd_in = {1'b0, rd_off[OFF_W-1:1]} < OFF_W'(HEAP_WORDS);
  assign wr_in = {1'b0, wr_off[OFF_W-1:1]} < OFF_W'(HEAP_WORDS);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in) begin
      words[wr_off[AW:1]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rd_in ? words[rd_off[AW:1]] : '0;
    end
  end

endmodule

// ===== dv/boundary_tag_heap_allocator_unit_tb.sv =====
`timescale 1ns / 100ps

module boundary_tag_heap_allocator_unit_tb;
  import btha_pkg::*;

  localparam int NUM_WORDS = 2048;
  localparam int CAP = (2 * NUM_WORDS > CAP_BYTES) ? CAP_BYTES : 2 * NUM_WORDS;
  localparam int RAND_PER_PHASE = 250;
  localparam int NUM_PHASES = 6;

  typedef struct {
    logic [1:0]  opcode;
    logic [12:0] request_bytes;
    logic [15:0] payload_addr;
  } heap_cmd_t;

  typedef struct {
    logic [15:0] result_addr;
    logic [1:0]  status;
  } heap_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  btha_req_if req ();
  btha_rsp_if rsp ();
  btha_cfg_if cfg ();

  boundary_tag_heap_allocator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the allocator state
  logic [15:0] shadow_mem [0:NUM_WORDS-1];
  int unsigned free_head, free_tail;
  bit          formatted;
  int unsigned base_reg, bytes_reg, base_act, size_act;

  heap_cmd_t   cmd_q [$];
  heap_rsp_t   rsp_q [$];
  int unsigned live_q [$];
  int unsigned mismatches;
  bit          quiet;
  bit          long_stall_req;

  function automatic int unsigned mem_rd(int unsigned off);
    return ((off >> 1) < NUM_WORDS) ? shadow_mem[off >> 1] : 0;
  endfunction

  function automatic void mem_wr(int unsigned off, int unsigned v);
    if ((off >> 1) < NUM_WORDS) shadow_mem[off >> 1] = v[15:0];
  endfunction

  function automatic void write_tags(int unsigned off, int unsigned sz, bit used);
    int unsigned t;
    t = (sz & TAG_SIZE) | (used ? TAG_ALLOC : 0);
    mem_wr(off, t);
    mem_wr(off + sz - 2, t);
  endfunction

  function automatic void write_free(int unsigned off, int unsigned sz,
                                     int unsigned prv, int unsigned nxt);
    write_tags(off, sz, 1'b0);
    mem_wr(off + 2, prv);
    mem_wr(off + 4, nxt);
  endfunction

  // Link 0 is the list sentinel
  function automatic void link_next(int unsigned node, int unsigned v);
    if (node == 0) free_head = v;
    else mem_wr(node + 4, v);
  endfunction

  function automatic void link_prev(int unsigned node, int unsigned v);
    if (node == 0) free_tail = v;
    else mem_wr(node + 2, v);
  endfunction

  function automatic void detach(int unsigned c);
    int unsigned p, n;
    p = mem_rd(c + 2) & 'hfff;
    n = mem_rd(c + 4) & 'hfff;
    link_next(p, n);
    link_prev(n, p);
  endfunction

  // First-fit walk with split
  function automatic heap_rsp_t alloc_chunk(int unsigned nbytes);
    heap_rsp_t   r;
    int unsigned need, node, cs, p, nx;
    r.result_addr = '0;
    r.status = ST_NOFIT;
    need = ((nbytes + 1) & ~32'd1) + 4;
    if (need < 8) need = 8;
    node = free_head;
    for (int n = 0; node != 0 && n < NUM_WORDS; n++) begin
      cs = mem_rd(node) & TAG_SIZE;
      if (cs >= need) begin
        if (cs - need >= 8) begin
          p = mem_rd(node + 2) & 'hfff;
          nx = mem_rd(node + 4) & 'hfff;
          write_free(node + need, cs - need, p, nx);
          link_next(p, node + need);
          link_prev(nx, node + need);
          write_tags(node, need, 1'b1);
        end else begin
          detach(node);
          write_tags(node, cs, 1'b1);
        end
        r.result_addr = 16'(base_act + node + 2);
        r.status = ST_OK;
        return r;
      end
      node = mem_rd(node + 4) & 'hfff;
    end
    return r;
  endfunction

  // Tag walk to validate, then coalesce and push at head
  function automatic logic [1:0] release_chunk(int unsigned addr);
    int unsigned diff, target, off, sz, t, noff, nsz, lt, rt, roff;
    bit          found;
    diff = (addr - base_act) & 'hffff;
    if (diff < 2) return ST_BAD_FREE;
    target = diff - 2;
    off = 4;
    sz = 0;
    found = 0;
    while (off + 8 <= size_act) begin
      t = mem_rd(off);
      sz = t & TAG_SIZE;
      if (sz < 8 || off + sz > size_act || off > target) break;
      if (off == target) begin
        found = (t & TAG_ALLOC) != 0;
        break;
      end
      off += sz;
    end
    if (!found) return ST_BAD_FREE;
    noff = off;
    nsz = sz;
    if (off > 4) begin
      lt = mem_rd(off - 2);
      if ((lt & TAG_ALLOC) == 0) begin
        noff = off - (lt & TAG_SIZE);
        detach(noff);
        nsz += lt & TAG_SIZE;
      end
    end
    roff = off + sz;
    if (roff < size_act) begin
      rt = mem_rd(roff);
      if ((rt & TAG_ALLOC) == 0) begin
        detach(roff);
        nsz += rt & TAG_SIZE;
      end
    end
    write_free(noff, nsz, 0, free_head);
    link_prev(free_head, noff);
    free_head = noff;
    return ST_OK;
  endfunction

  function automatic heap_rsp_t predict_heap(heap_cmd_t c);
    heap_rsp_t   r;
    int unsigned s;
    r.result_addr = '0;
    r.status = ST_OK;
    if (c.opcode == OP_INIT) begin
      s = bytes_reg & 'h1ffe;
      if (s > CAP) s = CAP;
      if (s < 16) s = 16;
      size_act = s;
      base_act = base_reg;
      write_free(4, s - 4, 0, 0);
      free_head = 4;
      free_tail = 4;
      formatted = 1;
    end else if (c.opcode == OP_NOP) begin
    end else if (!formatted) begin
      r.status = ST_NOT_INIT;
    end else if (c.opcode == OP_ALLOC) begin
      r = alloc_chunk(c.request_bytes);
    end else begin
      r.status = release_chunk(c.payload_addr);
    end
    return r;
  endfunction

  // Queue a command with its expected response and track live blocks
  task automatic issue(logic [1:0] op, logic [12:0] nb, logic [15:0] pa);
    heap_cmd_t c;
    heap_rsp_t r;
    c.opcode = op;
    c.request_bytes = nb;
    c.payload_addr = pa;
    r = predict_heap(c);
    cmd_q.push_back(c);
    rsp_q.push_back(r);
    if (op == OP_INIT) live_q.delete();
    else if (op == OP_ALLOC && r.status == ST_OK) live_q.push_back(r.result_addr);
    else if (op == OP_FREE && r.status == ST_OK) begin
      foreach (live_q[i])
        if (live_q[i] == pa) begin
          live_q.delete(i);
          break;
        end
    end
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == CFG_HEAP_BASE) base_reg = v;
    else bytes_reg = v & 'h1fff;
  endtask

  task automatic random_item();
    int unsigned k, sel;
    logic [12:0] nb;
    k = $urandom_range(0, 99);
    if (k < 2) issue(OP_INIT, 13'($urandom), 16'($urandom));
    else if (k < 5) issue(OP_NOP, 13'($urandom), 16'($urandom));
    else if (k < 52) begin
      sel = $urandom_range(0, 19);
      if (sel < 13) nb = 13'($urandom_range(0, 40));
      else if (sel < 19) nb = 13'($urandom_range(0, 300));
      else nb = 13'($urandom_range(0, 8191));
      issue(OP_ALLOC, nb, 16'($urandom));
    end else begin
      sel = $urandom_range(0, 9);
      if (live_q.size() != 0 && sel < 8)
        issue(OP_FREE, 13'($urandom), 16'(live_q[$urandom_range(0, live_q.size() - 1)]));
      else if (sel == 8)
        issue(OP_FREE, 13'($urandom), 16'(base_act + 2 * $urandom_range(0, 40)));
      else
        issue(OP_FREE, 13'($urandom), 16'($urandom));
    end
  endtask

  // Command driver
  int unsigned send_gap;
  heap_cmd_t   next_cmd;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_gap <= 0;
    end else if (!req.valid || req.ready) begin
      if (send_gap != 0) begin
        req.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        req.valid <= 1'b0;
        send_gap <= $urandom_range(1, 16);
      end else if (cmd_q.size() != 0) begin
        next_cmd = cmd_q.pop_front();
        req.valid <= 1'b1;
        req.opcode <= next_cmd.opcode;
        req.request_bytes <= next_cmd.request_bytes;
        req.payload_addr <= next_cmd.payload_addr;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Response ready, with one long hold-off to back up the pipe
  int unsigned recv_gap, long_left;
  bit          long_done;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_gap <= 0;
      long_left <= 0;
      long_done <= 1'b0;
    end else if (long_left != 0) begin
      rsp.ready <= 1'b0;
      long_left <= long_left - 1;
    end else if (long_stall_req && !long_done) begin
      rsp.ready <= 1'b0;
      long_done <= 1'b1;
      long_left <= 400;
    end else if (recv_gap != 0) begin
      rsp.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      rsp.ready <= 1'b0;
      recv_gap <= $urandom_range(1, 16);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Response checker
  heap_rsp_t want;
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response addr=%h status=%0d", rsp.result_addr, rsp.status);
      end else begin
        want = rsp_q.pop_front();
        if (rsp.result_addr !== want.result_addr || rsp.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                     want.result_addr, want.status, rsp.result_addr, rsp.status);
        end
      end
    end
  end

  // Stimulus
  logic [15:0] cfg_base  [NUM_PHASES] = '{16'd0, 16'd65534, 16'hfff0, 16'd1234,
                                          16'd40960, 16'd777};
  logic [15:0] cfg_bytes [NUM_PHASES] = '{16'd16, 16'd4096, 16'd8191, 16'd257,
                                          16'd0, 16'd600};
  int unsigned a0, a1, a2;
  initial begin
    cfg.valid = 1'b0;
    cfg.reg_index = CFG_HEAP_BASE;
    cfg.wdata = '0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    free_head = 0;
    free_tail = 0;
    formatted = 0;
    base_reg = 40960;
    bytes_reg = 256;
    base_act = 0;
    size_act = 0;
    mismatches = 0;
    quiet = 0;
    long_stall_req = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: unformatted heap, sizing edges, bad frees, two-sided merge
    issue(OP_ALLOC, 13'd5, 16'h0);
    issue(OP_FREE, 13'h0, 16'hffff);
    issue(OP_NOP, 13'h1fff, 16'hffff);
    issue(OP_INIT, 13'h0, 16'h0);
    issue(OP_ALLOC, 13'd0, 16'h0);
    issue(OP_ALLOC, 13'd1, 16'h0);
    issue(OP_ALLOC, 13'd8191, 16'h0);
    issue(OP_ALLOC, 13'd20, 16'h0);
    a0 = live_q[live_q.size() - 1];
    issue(OP_ALLOC, 13'd30, 16'h0);
    a1 = live_q[live_q.size() - 1];
    issue(OP_ALLOC, 13'd11, 16'h0);
    a2 = live_q[live_q.size() - 1];
    issue(OP_FREE, 13'h0, 16'(a0));
    issue(OP_FREE, 13'h0, 16'(a2));
    issue(OP_FREE, 13'h0, 16'(a1));
    issue(OP_FREE, 13'h0, 16'(a1));
    issue(OP_FREE, 13'h0, 16'(a0 + 1));
    issue(OP_FREE, 13'h0, 16'(base_act));
    issue(OP_FREE, 13'h0, 16'hffff);
    issue(OP_ALLOC, 13'd190, 16'h0);
    issue(OP_ALLOC, 13'd400, 16'h0);
    issue(OP_FREE, 13'h0, 16'(base_act + 6));
    issue(OP_INIT, 13'h0, 16'h0);
    issue(OP_ALLOC, 13'd246, 16'h0);
    issue(OP_ALLOC, 13'd0, 16'h0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Sender holds until the pipe is empty before touching registers
      drain();
      repeat (20) @(posedge clk);
      write_reg(CFG_HEAP_BASE, cfg_base[ph]);
      write_reg(CFG_HEAP_BYTES, cfg_bytes[ph]);
      if (ph == NUM_PHASES - 1) quiet = 1;
      issue(OP_INIT, 13'($urandom), 16'($urandom));
      for (int i = 0; i < RAND_PER_PHASE; i++) random_item();
      if (ph == 1) begin
        repeat (30) @(posedge clk);
        long_stall_req = 1;
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && rsp_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #200000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
